### hw/rtl/bde_pkg.sv
// Shared types and codes for the button debounce event block.
// No dependencies; imported by the interface users and the top level.
package bde_pkg;

  localparam int unsigned NOW_WIDTH      = 32;
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned CFG_DATA_WIDTH = 16;
  localparam int unsigned VALUE_WIDTH    = 7;

  localparam logic [VALUE_WIDTH-1:0] NOTE_ON_VALUE   = 7'd127;
  localparam logic [VALUE_WIDTH-1:0] NOTE_OFF_VALUE  = 7'd0;
  localparam logic [VALUE_WIDTH-1:0] CC_ON_RESET     = 7'd127;
  localparam logic [VALUE_WIDTH-1:0] CC_OFF_RESET    = 7'd0;
  localparam logic [15:0]            DEBOUNCE_RESET  = 16'd50;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PULL_POLARITY  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BUTTON_MODE    = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PULSE_ON_PRESS = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MESSAGE_KIND   = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CC_ON_VALUE    = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CC_OFF_VALUE   = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE_MS    = 3'd6;

  localparam logic [1:0] POL_PULLUP   = 2'd0;
  localparam logic [1:0] POL_PULLDOWN = 2'd1;

  localparam logic [1:0] MODE_PRESS_RELEASE = 2'd0;
  localparam logic [1:0] MODE_PULSE         = 2'd1;
  localparam logic [1:0] MODE_TOGGLE        = 2'd2;

  localparam logic [2:0] KIND_NOTE    = 3'd0;
  localparam logic [2:0] KIND_CC      = 3'd1;
  localparam logic [2:0] KIND_PROGRAM = 3'd2;
  localparam logic [2:0] KIND_CLOCK   = 3'd3;
  localparam logic [2:0] KIND_TAP     = 3'd4;

  typedef struct packed {
    logic                 raw_level;
    logic [NOW_WIDTH-1:0] now_ms;
  } bde_in_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] midi_value;
    logic                   is_on_event;
    logic                   from_press;
    logic                   last_of_run;
  } bde_out_t;

endpackage

### hw/rtl/bde_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is a parameter; no other dependencies.
interface bde_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/button_debounce_midi_event.sv
// Debounced button to MIDI on/off event generator, top level.
// Depends on bde_pkg and bde_stream_if.
//
// Each input transaction is one poll (pin level and millisecond timestamp); each poll yields
// zero, one or two event transactions, the last one flagged by last_of_run. A poll is held
// in an input register while it is evaluated against the debounce state; its events go into
// a two-entry output buffer that must have drained before the next poll is evaluated. Polls
// that give at most one event sustain one per cycle while the output is ready; a pulse's on
// and off events drain through the single output port. A poll passes the input register and
// its events the output buffer. Configuration is written by a plain write port and takes
// effect on the next poll; write it only while the block is idle.
module button_debounce_midi_event
  import bde_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i,
  bde_stream_if.sink                in_i,
  bde_stream_if.source              out_o
);

  logic [1:0]             pull_polarity_q;
  logic [1:0]             button_mode_q;
  logic                   pulse_on_press_q;
  logic [2:0]             message_kind_q;
  logic [VALUE_WIDTH-1:0] cc_on_value_q;
  logic [VALUE_WIDTH-1:0] cc_off_value_q;
  logic [15:0]            debounce_ms_q;

  logic                   in_valid_q;
  bde_in_t                in_q;

  logic                   primed_q;
  logic                   last_seen_q;
  logic [TIME_WIDTH-1:0]  change_ts_q;
  logic                   stable_q;
  logic                   pulse_pending_q;
  logic                   toggle_on_q;

  bde_out_t               slot_q [2];
  logic [1:0]             cnt_q;

  logic                   pop;
  logic                   proc_fire;
  logic [TIME_WIDTH-1:0]  now_w;
  logic                   pressed;
  logic                   changed;
  logic [TIME_WIDTH-1:0]  ts_eff;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   settled;
  logic                   press_edge;
  logic                   release_edge;
  logic                   emit_on;
  logic                   emit_off;
  logic                   edge_press;
  logic                   suppress_off;
  logic                   off_sent;
  logic                   pulse_pending_d;
  logic                   toggle_on_d;
  logic [1:0]             n_res;
  bde_out_t               on_item;
  bde_out_t               off_item;
  bde_out_t               res0;
  bde_out_t               res1;

  if (TIME_WIDTH > NOW_WIDTH) begin : g_now_ext
    assign now_w = {{(TIME_WIDTH - NOW_WIDTH){1'b0}}, in_q.now_ms};
  end else begin : g_now_trunc
    assign now_w = in_q.now_ms[TIME_WIDTH-1:0];
  end

  assign pop       = out_o.valid && out_o.ready;
  assign proc_fire = in_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_i.ready = !in_valid_q || proc_fire;
  assign out_o.valid   = (cnt_q != 2'd0);
  assign out_o.payload = slot_q[0];

  assign pressed = (pull_polarity_q == POL_PULLDOWN) ? in_q.raw_level : !in_q.raw_level;
  assign changed = pressed != last_seen_q;
  assign ts_eff  = changed ? now_w : change_ts_q;
  assign elapsed = now_w - ts_eff;
  assign settled = primed_q && (elapsed >= {{(TIME_WIDTH - 16){1'b0}}, debounce_ms_q});
  assign press_edge   = settled && pressed && !stable_q;
  assign release_edge = settled && !pressed && stable_q;

  assign suppress_off = (message_kind_q == KIND_PROGRAM) || (message_kind_q == KIND_CLOCK) ||
                        (message_kind_q == KIND_TAP);

  always_comb begin
    emit_on         = 1'b0;
    emit_off        = 1'b0;
    edge_press      = press_edge;
    pulse_pending_d = pulse_pending_q;
    toggle_on_d     = toggle_on_q;
    if (press_edge) begin
      unique case (button_mode_q)
        MODE_PULSE: begin
          if (pulse_on_press_q) begin
            emit_on  = 1'b1;
            emit_off = 1'b1;
          end else begin
            pulse_pending_d = 1'b1;
          end
        end
        MODE_TOGGLE: begin
          emit_on     = !toggle_on_q;
          emit_off    = toggle_on_q;
          toggle_on_d = !toggle_on_q;
        end
        default: emit_on = 1'b1;
      endcase
    end else if (release_edge) begin
      unique case (button_mode_q)
        MODE_PULSE: begin
          if (pulse_pending_q) begin
            emit_on         = 1'b1;
            emit_off        = 1'b1;
            pulse_pending_d = 1'b0;
          end
        end
        MODE_TOGGLE: ;
        default: emit_off = 1'b1;
      endcase
    end
  end

  assign off_sent = emit_off && !suppress_off;
  assign n_res    = {1'b0, emit_on} + {1'b0, off_sent};

  always_comb begin
    on_item.midi_value  = (message_kind_q == KIND_CC) ? cc_on_value_q : NOTE_ON_VALUE;
    on_item.is_on_event = 1'b1;
    on_item.from_press  = edge_press;
    on_item.last_of_run = !off_sent;
    off_item.midi_value  = (message_kind_q == KIND_CC) ? cc_off_value_q : NOTE_OFF_VALUE;
    off_item.is_on_event = 1'b0;
    off_item.from_press  = edge_press;
    off_item.last_of_run = 1'b1;
    res0 = emit_on ? on_item : off_item;
    res1 = off_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pull_polarity_q  <= POL_PULLUP;
      button_mode_q    <= MODE_PRESS_RELEASE;
      pulse_on_press_q <= 1'b0;
      message_kind_q   <= KIND_NOTE;
      cc_on_value_q    <= CC_ON_RESET;
      cc_off_value_q   <= CC_OFF_RESET;
      debounce_ms_q    <= DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PULL_POLARITY:  pull_polarity_q  <= cfg_wdata_i[1:0];
        CFG_BUTTON_MODE:    button_mode_q    <= cfg_wdata_i[1:0];
        CFG_PULSE_ON_PRESS: pulse_on_press_q <= cfg_wdata_i[0];
        CFG_MESSAGE_KIND:   message_kind_q   <= cfg_wdata_i[2:0];
        CFG_CC_ON_VALUE:    cc_on_value_q    <= cfg_wdata_i[VALUE_WIDTH-1:0];
        CFG_CC_OFF_VALUE:   cc_off_value_q   <= cfg_wdata_i[VALUE_WIDTH-1:0];
        CFG_DEBOUNCE_MS:    debounce_ms_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q        <= 1'b0;
      last_seen_q     <= 1'b0;
      change_ts_q     <= '0;
      stable_q        <= 1'b0;
      pulse_pending_q <= 1'b0;
      toggle_on_q     <= 1'b0;
    end else if (proc_fire) begin
      last_seen_q <= pressed;
      if (!primed_q) begin
        primed_q    <= 1'b1;
        stable_q    <= pressed;
        change_ts_q <= now_w;
      end else begin
        change_ts_q <= ts_eff;
        if (settled) begin
          stable_q <= pressed;
        end
        pulse_pending_q <= pulse_pending_d;
        toggle_on_q     <= toggle_on_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (proc_fire) begin
      cnt_q <= n_res;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      slot_q[0] <= res0;
      slot_q[1] <= res1;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && (n_res == 2'd2) |=> out_o.valid && slot_q[0].is_on_event &&
    !slot_q[0].last_of_run && !slot_q[1].is_on_event)
    else $error("pulse pair not queued on then off");

  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> slot_q[1].last_of_run)
    else $error("second buffered event not flagged as last");

  a_hold_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc_fire |=> in_valid_q && $stable(in_q))
    else $error("pending poll lost before evaluation");

  a_no_emit_unprimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && !primed_q |-> n_res == 2'd0)
    else $error("event emitted on priming poll");
`endif

endmodule
